// ----- rtl/pie_pkg.sv -----
`default_nettype none
package pie_pkg;
  localparam int unsigned VecW = 48;
  localparam int unsigned EntW = 32;
  localparam int unsigned IdxW = 5;
  localparam int unsigned ResultLimit = 32;
  localparam int unsigned CfgW = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [VecW-1:0] VecOne = 48'h0001_0000_0000;
  localparam logic [VecW-1:0] VecMax = {VecW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_MATRIX_SIZE = 1'b0,
    REG_ITERATION_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_RUN = 1'b1
  } op_t;

  typedef struct packed {
    logic [0:0] opcode;
    logic [IdxW-1:0] row_index;
    logic [IdxW-1:0] col_index;
    logic [EntW-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] element_index;
    logic [EntW-1:0] element_fraction;
    logic [0:0] last_element;
    logic [0:0] saturated;
  } out_item_t;
endpackage
`default_nettype wire

// ----- rtl/pie_if.sv -----
`default_nettype none
interface pie_in_if import pie_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pie_out_if import pie_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/power_iteration_eigenvector_top.sv -----
// Power iteration for the dominant eigenvector. Opcode 0 writes one Q1.31
// matrix entry. Opcode 1 starts a run: one multiply-accumulate unit walks
// every matrix entry, one per cycle within a row, then drains its pipeline;
// each row ends with a write-back and each pass with a copy of the vector.
// After the last pass the vector is summed, then each of the n outputs
// goes through a 33-step bit-serial divider and waits for out_ch.ready.
// The input is not ready during a run.
// Saturation of any element is reported on every output of that run.
`default_nettype none
module power_iteration_eigenvector_top import pie_pkg::*; #(
  parameter int unsigned MAX_SIZE = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  pie_in_if.sink in_ch,
  pie_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0] cfg_data
);
  localparam int unsigned MW = $clog2(MAX_SIZE*MAX_SIZE);
  localparam int unsigned LIM = (MAX_SIZE < ResultLimit) ? MAX_SIZE : ResultLimit;
  localparam int unsigned NW = $clog2(LIM + 1);
  localparam int unsigned VW = (LIM > 1) ? $clog2(LIM) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_ROWEND, S_COPY, S_SUM, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [5:0] matrix_size;
  logic [7:0] iteration_count;
  logic [EntW-1:0] mem [MAX_SIZE*MAX_SIZE];
  logic [VecW-1:0] cur [LIM];
  logic [VecW-1:0] nxt [LIM];
  logic [NW-1:0] n;
  logic [VW-1:0] row, col;
  logic [7:0] iter;
  logic sat;
  // pipeline: stage1 read mem + vec, stage2 two half multiplies,
  // stage3 round, stage4 accumulate
  logic v1, v2, v3;
  logic [EntW-1:0] p_q;
  logic [VecW-1:0] vq;
  logic [55:0] mul_hi;
  logic [55:0] mul_lo;
  logic [56:0] low_sum;
  logic [VecW:0] prod;
  logic [VecW+6:0] acc;
  logic [VecW+6:0] total;
  logic [VecW+6:0] rem;
  logic [EntW:0] quo;
  logic [5:0] step;
  logic [VecW+7:0] rem2;

  logic [NW-1:0] n_eff;
  always_comb begin
    if (matrix_size == 6'd0) n_eff = NW'(1);
    else if (32'(matrix_size) > LIM) n_eff = NW'(LIM);
    else n_eff = NW'(matrix_size);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign rem2 = {rem, 1'b0};
  assign low_sum = {26'd0, mul_hi[6:0], 24'd0} + {1'b0, mul_lo};

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.data.opcode == OP_WRITE &&
        32'(in_ch.data.row_index) < MAX_SIZE && 32'(in_ch.data.col_index) < MAX_SIZE)
      mem[MW'(in_ch.data.row_index) * MW'(MAX_SIZE) + MW'(in_ch.data.col_index)]
        <= in_ch.data.entry_value;
    p_q <= mem[MW'(row) * MW'(MAX_SIZE) + MW'(col)];
    vq <= cur[col];
    mul_hi <= 56'(vq[47:24]) * 56'(p_q);
    mul_lo <= 56'(vq[23:0]) * 56'(p_q) + (56'd1 << 30);
    prod <= mul_hi[55:7] + (VecW+1)'(low_sum[56:31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      matrix_size <= 6'd32;
      iteration_count <= 8'd90;
      sat <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MATRIX_SIZE: matrix_size <= cfg_data[5:0];
          REG_ITERATION_COUNT: iteration_count <= cfg_data;
          default: ;
        endcase
      end
      v1 <= (state == S_MAC);
      v2 <= v1;
      v3 <= v2;
      if (v3) acc <= acc + (VecW+7)'(prod);
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.data.opcode == OP_RUN) begin
            n <= n_eff;
            sat <= 1'b0;
            for (int k = 0; k < LIM; k++) cur[k] <= VecOne;
            iter <= 8'd0;
            row <= '0;
            col <= '0;
            acc <= '0;
            state <= (iteration_count == 8'd0) ? S_SUM : S_MAC;
            total <= '0;
          end
        end
        S_MAC: begin
          if (32'(col) + 1 == 32'(n)) state <= S_DRAIN;
          else col <= col + VW'(1);
          step <= '0;
        end
        S_DRAIN: begin
          // wait for the last product to reach the accumulator
          step <= step + 6'd1;
          if (step == 6'd3) state <= S_ROWEND;
        end
        S_ROWEND: begin
          if (acc > (VecW+7)'(VecMax)) begin
            nxt[row] <= VecMax;
            sat <= 1'b1;
          end else nxt[row] <= VecW'(acc);
          acc <= '0;
          col <= '0;
          if (32'(row) + 1 == 32'(n)) begin
            row <= '0;
            state <= S_COPY;
          end else begin
            row <= row + VW'(1);
            state <= S_MAC;
          end
        end
        S_COPY: begin
          for (int k = 0; k < LIM; k++) cur[k] <= nxt[k];
          iter <= iter + 8'd1;
          if (iter + 8'd1 == iteration_count) state <= S_SUM;
          else state <= S_MAC;
        end
        S_SUM: begin
          total <= total + (VecW+7)'(cur[row]);
          if (32'(row) + 1 == 32'(n)) begin
            row <= '0;
            state <= S_DIV;
            rem <= (VecW+7)'(cur[0]);
            quo <= '0;
            step <= '0;
          end else row <= row + VW'(1);
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle, then round
          if (step == 6'd0) begin
            if (rem >= total) begin
              rem <= rem - total;
              quo <= (EntW+1)'(1);
            end
            step <= 6'd1;
          end else if (step <= 6'd31) begin
            if (rem2 >= {1'b0, total}) begin
              rem <= (VecW+7)'(rem2 - {1'b0, total});
              quo <= {quo[EntW-1:0], 1'b1};
            end else begin
              rem <= (VecW+7)'(rem2);
              quo <= {quo[EntW-1:0], 1'b0};
            end
            step <= step + 6'd1;
          end else begin
            out_ch.valid <= 1'b1;
            out_ch.data.element_index <= IdxW'(row);
            out_ch.data.element_fraction <= (total == '0) ? '0 :
              EntW'(quo + ((rem2 >= {1'b0, total}) ? (EntW+1)'(1) : '0));
            out_ch.data.last_element <= (32'(row) + 1 == 32'(n));
            out_ch.data.saturated <= sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (32'(row) + 1 == 32'(n)) state <= S_IDLE;
            else begin
              row <= row + VW'(1);
              rem <= (VecW+7)'(cur[row + VW'(1)]);
              quo <= '0;
              step <= '0;
              state <= S_DIV;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pie_checker.sv -----
`default_nettype none
module pie_checker import pie_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while output pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("run ended before last element");
endmodule

bind power_iteration_eigenvector_top pie_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last_element[0])
);
`default_nettype wire
